// ===== hdl/dmskt_pkg.sv =====
package dmskt_pkg;

  // Number of table slots. The hash is reduced by masking, so this stays a power of two.
  localparam int SLOTS  = 16;
  localparam int HASH_W = $clog2(SLOTS);

  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_DELETE = 2'd2;

  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_MISS = 2'd1;
  localparam logic [1:0] STATUS_LONG = 2'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] key_byte;
    logic       key_last;
    logic [7:0] entry_value;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [7:0]        found_value;
    logic [HASH_W-1:0] slot;
  } rsp_t;

  typedef enum logic [1:0] {
    S_RECV,
    S_CHECK,
    S_LOOP,
    S_RESULT
  } state_t;

endpackage

// ===== hdl/direct_mapped_string_key_table.sv =====
// Direct-mapped table with string keys and byte values.
// The request channel (req_valid, req_stall, req) carries one key byte per word; the word
// with key_last set also carries the operation (insert, lookup, delete) and the insert value.
// Each byte taken updates the running hash and, while the buffer has room, goes into the key buffer.
// After the final byte the block stalls the request channel while it works on the one slot
// the hash picked. A check state decides the easy outcomes. Then a byte loop either
// copies the buffered key into the slot's key memory (insert) or compares it with the stored
// key (lookup and delete). The loop runs through the single read port of each key memory,
// one byte per cycle. A result state writes the result word and updates the slot's
// valid mark. No loop is needed when the slot is busy (insert), the lengths differ
// (lookup, delete) or the key is too long.
// The response channel (rsp_valid, rsp_stall, rsp) is a register. Key bytes keep being
// taken while a result word waits; only the next result waits for the register to free up.
// Reset (rst, synchronous) empties the table through its valid marks and clears the hash and
// key state; stored keys and values are not cleared and are read only behind a valid mark.
module direct_mapped_string_key_table
  import dmskt_pkg::*;
#(
  parameter int MAX_KEY_LEN = 255
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  // Length counter holds 0..MAX_KEY_LEN; byte indexes run 0..MAX_KEY_LEN-1.
  localparam int LW    = $clog2(MAX_KEY_LEN + 1);
  localparam int KAW   = (MAX_KEY_LEN > 1) ? $clog2(MAX_KEY_LEN) : 1;
  localparam int DEPTH = SLOTS * MAX_KEY_LEN;
  localparam int SAW   = $clog2(DEPTH);

  state_t state, state_next;

  // Key being streamed in.
  logic [HASH_W-1:0] hash;
  logic [LW-1:0]     key_len;
  logic              too_long;

  // Operation captured with the final byte.
  logic [1:0]        op_mode;
  logic [7:0]        op_value;
  logic [HASH_W-1:0] op_slot;

  // Byte loop.
  logic              is_copy;
  logic [SAW-1:0]    base;
  logic [LW-1:0]     rd_cnt;
  logic              pipe_v;
  logic [KAW-1:0]    pipe_idx;
  logic              mismatch;
  logic [1:0]        res_status;

  // Table.
  logic [SLOTS-1:0]  slot_valid;
  logic [LW-1:0]     slot_len [SLOTS];
  logic [7:0]        slot_val [SLOTS];
  logic [7:0]        key_buf  [MAX_KEY_LEN];
  logic [7:0]        slot_mem [DEPTH];
  logic [7:0]        kb_rdata;
  logic [7:0]        sk_rdata;

  logic                req_accept;
  logic [HASH_W-1:0]   key_lo;
  logic [HASH_W-1:0]   hash_sum;
  logic [2*HASH_W-1:0] hash_prod;
  logic [HASH_W-1:0]   hash_new;
  logic                buf_full;
  logic [KAW-1:0]      rd_idx;
  logic                issue;
  logic                loop_done;
  logic                rsp_free;
  logic                check_go;
  logic [1:0]          check_status;
  logic [SAW-1:0]      base_calc;
  logic                res_ok;
  logic                res_hit;

  // The hash only ever needs its low bits, so the update runs on narrow operands.
  assign key_lo    = req.key_byte[HASH_W-1:0];
  assign hash_sum  = hash + key_lo;
  assign hash_prod = (2*HASH_W)'(hash_sum) * (2*HASH_W)'(key_lo);
  assign hash_new  = hash_prod[HASH_W-1:0];

  assign req_accept = req_valid && !req_stall;
  assign buf_full   = (key_len == LW'(MAX_KEY_LEN));
  assign rd_idx     = rd_cnt[KAW-1:0];
  assign rsp_free   = !rsp_valid || !rsp_stall;
  assign base_calc  = SAW'(op_slot) * SAW'(MAX_KEY_LEN);
  assign res_ok     = (res_status == STATUS_OK);
  assign res_hit    = res_ok && (op_mode == MODE_LOOKUP || op_mode == MODE_DELETE);

  // Outcome of the check cycle; check_go sends the key through the byte loop.
  always_comb begin
    check_go     = 1'b0;
    check_status = STATUS_MISS;
    priority if (too_long) begin
      check_status = STATUS_LONG;
    end else if (op_mode == MODE_INSERT) begin
      check_go = !slot_valid[op_slot];
    end else if (op_mode == MODE_LOOKUP || op_mode == MODE_DELETE) begin
      check_go = slot_valid[op_slot] && (slot_len[op_slot] == key_len);
    end else begin
      check_status = STATUS_MISS;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_RECV: begin
        if (req_accept && req.key_last) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        state_next = check_go ? S_LOOP : S_RESULT;
      end
      S_LOOP: begin
        if (loop_done) begin
          state_next = S_RESULT;
        end
      end
      S_RESULT: begin
        if (rsp_free) begin
          state_next = S_RECV;
        end
      end
      default: state_next = S_RECV;
    endcase
  end

  always_comb begin
    req_stall = (state != S_RECV);
    issue     = (state == S_LOOP) && (rd_cnt != key_len);
    loop_done = (state == S_LOOP) && !issue && !pipe_v;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_RECV;
      hash       <= '0;
      key_len    <= '0;
      too_long   <= 1'b0;
      rd_cnt     <= '0;
      pipe_v     <= 1'b0;
      mismatch   <= 1'b0;
      rsp_valid  <= 1'b0;
      slot_valid <= '0;
    end else begin
      state  <= state_next;
      pipe_v <= issue;

      if (req_accept) begin
        hash <= hash_new;
        if (!buf_full) begin
          key_len <= key_len + 1'b1;
        end else begin
          too_long <= 1'b1;
        end
      end

      if (state == S_CHECK) begin
        rd_cnt   <= '0;
        mismatch <= 1'b0;
      end

      if (issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end

      // Stored byte and buffered byte arrive together in the cycle after the read.
      if (pipe_v && !is_copy && (kb_rdata != sk_rdata)) begin
        mismatch <= 1'b1;
      end

      if (state == S_RESULT && rsp_free) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end

      if (state == S_RESULT && rsp_free) begin
        hash      <= '0;
        key_len   <= '0;
        too_long  <= 1'b0;
        if (res_ok && op_mode == MODE_INSERT) begin
          slot_valid[op_slot] <= 1'b1;
        end
        if (res_ok && op_mode == MODE_DELETE) begin
          slot_valid[op_slot] <= 1'b0;
        end
      end
    end
  end

  // Operation and loop data registers, which need no reset.
  always_ff @(posedge clk) begin
    if (req_accept && req.key_last) begin
      op_mode  <= req.mode;
      op_value <= req.entry_value;
      op_slot  <= hash_new;
    end
    if (state == S_CHECK) begin
      base       <= base_calc;
      is_copy    <= (op_mode == MODE_INSERT);
      res_status <= check_status;
    end
    if (loop_done) begin
      res_status <= (is_copy || !mismatch) ? STATUS_OK : STATUS_MISS;
    end
    pipe_idx <= rd_idx;
    if (state == S_RESULT && rsp_free) begin
      rsp.status      <= res_status;
      rsp.found_value <= res_hit ? slot_val[op_slot] : 8'd0;
      rsp.slot        <= op_slot;
      if (res_ok && op_mode == MODE_INSERT) begin
        slot_len[op_slot] <= key_len;
        slot_val[op_slot] <= op_value;
      end
    end
  end

  // Key buffer: written as bytes stream in, read by the byte loop.
  always_ff @(posedge clk) begin
    if (req_accept && !buf_full) begin
      key_buf[key_len[KAW-1:0]] <= req.key_byte;
    end
    kb_rdata <= key_buf[rd_idx];
  end

  // Stored keys, one row of MAX_KEY_LEN bytes per slot.
  always_ff @(posedge clk) begin
    if (pipe_v && is_copy) begin
      slot_mem[base + SAW'(pipe_idx)] <= kb_rdata;
    end
    sk_rdata <= slot_mem[base + SAW'(rd_idx)];
  end

  a_rsp_from_result: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state == S_RESULT))
    else $error("response word appeared outside the result cycle");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    key_len <= LW'(MAX_KEY_LEN))
    else $error("key length passed the buffer size");

  a_loop_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_LOOP) |-> (rd_cnt <= key_len))
    else $error("byte loop ran past the key length");

  a_last_to_check: assert property (@(posedge clk) disable iff (rst)
    (req_accept && req.key_last) |=> (state == S_CHECK && req_stall))
    else $error("final byte did not start the slot check");

endmodule
